/* design/assert_macros.svh */
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/nwed_pkg.sv */
package nwed_pkg;

	localparam int MAX_WORD   = 64;
	localparam int INDEX_BITS = 16;

	localparam logic [1:0] MODE_QUERY = 2'd0;
	localparam logic [1:0] MODE_DICT  = 2'd1;
	localparam logic [1:0] MODE_END   = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CELL,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load_query;
		logic dict_start;
		logic emit;
		logic step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic len_zero;
		logic last_cell;
	} sts_t;

endpackage

/* design/nwed_ctrl.sv */
`include "assert_macros.svh"

module nwed_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           mode,
	input  nwed_pkg::sts_t       sts,
	output logic                 busy,
	output nwed_pkg::cmd_t       cmd
);

	nwed_pkg::state_t state_q, state_d;
	logic accept;

	assign accept = start && (state_q == nwed_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nwed_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nwed_pkg::ST_IDLE: begin
				if (accept && (mode == nwed_pkg::MODE_DICT)) begin
					state_d = sts.len_zero ? nwed_pkg::ST_FINISH : nwed_pkg::ST_CELL;
				end
			end
			nwed_pkg::ST_CELL: begin
				if (sts.last_cell) begin
					state_d = nwed_pkg::ST_FINISH;
				end
			end
			nwed_pkg::ST_FINISH: begin
				state_d = nwed_pkg::ST_IDLE;
			end
			default: begin
				state_d = nwed_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy           = (state_q != nwed_pkg::ST_IDLE);
		cmd.load_query = accept && (mode == nwed_pkg::MODE_QUERY);
		cmd.dict_start = accept && (mode == nwed_pkg::MODE_DICT);
		cmd.emit       = accept && (mode == nwed_pkg::MODE_END);
		cmd.step       = (state_q == nwed_pkg::ST_CELL);
		cmd.finish     = (state_q == nwed_pkg::ST_FINISH);
	end

	`ASSERT_NXT(a_dict_goes_busy, clk, arst_n, cmd.dict_start, busy,
		"dictionary item did not start a row update")
	`ASSERT_NXT(a_last_cell_finish, clk, arst_n, cmd.step && sts.last_cell,
		cmd.finish, "row update did not finish after its last cell")

endmodule

/* design/nwed_dp.sv */
`include "assert_macros.svh"

module nwed_dp #(
	parameter int MAX_WORD   = nwed_pkg::MAX_WORD,
	parameter int INDEX_BITS = nwed_pkg::INDEX_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  nwed_pkg::cmd_t        cmd,
	input  logic [7:0]            symbol,
	input  logic                  word_last,
	input  logic                  cfg_we,
	input  logic [7:0]            cfg_data,
	output nwed_pkg::sts_t        sts,
	output logic                  done,
	output logic                  found,
	output logic [INDEX_BITS-1:0] best_index,
	output logic [7:0]            best_distance
);

	localparam int AW = $clog2(MAX_WORD);
	localparam int LW = $clog2(MAX_WORD + 1);
	localparam logic [LW-1:0] MAX_LEN = LW'(MAX_WORD);

	logic [7:0]            query_mem [MAX_WORD];
	logic [7:0]            row_mem [MAX_WORD];
	logic [MAX_WORD-1:0]   row_valid_q;

	logic [7:0]            max_distance_q;
	logic [LW-1:0]         qlen_q;
	logic [7:0]            row0_q;
	logic [INDEX_BITS-1:0] cnt_q;
	logic [7:0]            best_q;
	logic [INDEX_BITS-1:0] pos_q;
	logic                  any_q;

	logic [7:0]            sym_q;
	logic                  last_q;
	logic [AW-1:0]         k_q;
	logic [7:0]            diag_q;
	logic [7:0]            left_q;

	logic [7:0]            q_rd_s1;
	logic [7:0]            row_rd_s1;
	logic                  row_vld_s1;

	logic                  done_q;
	logic                  found_q;
	logic [INDEX_BITS-1:0] best_index_q;
	logic [7:0]            best_distance_q;

	logic [AW-1:0]         rd_addr;
	logic [7:0]            row0_inc;
	logic [7:0]            up;
	logic [8:0]            c_diag, c_left, c_up, c_min;
	logic [7:0]            cost;
	logic                  restart;
	logic                  word_end;

	assign row0_inc = (row0_q == 8'hFF) ? row0_q : row0_q + 8'd1;
	assign rd_addr  = cmd.dict_start ? '0 : k_q + AW'(1);
	assign up       = row_vld_s1 ? row_rd_s1 : 8'(k_q) + 8'd1;

	always_comb begin
		c_diag = {1'b0, diag_q} + ((q_rd_s1 != sym_q) ? 9'd1 : 9'd0);
		c_left = {1'b0, left_q} + 9'd1;
		c_up   = {1'b0, up} + 9'd1;
		c_min  = c_diag;
		if (c_left < c_min) begin
			c_min = c_left;
		end
		if (c_up < c_min) begin
			c_min = c_up;
		end
		cost = c_min[8] ? 8'hFF : c_min[7:0];
	end

	assign word_end = cmd.finish && last_q;
	assign restart  = cmd.load_query || cmd.emit || word_end;

	assign sts.len_zero  = (qlen_q == '0);
	assign sts.last_cell = ((LW'(k_q) + LW'(1)) == qlen_q);

	always_ff @(posedge clk) begin
		if (cmd.load_query && (qlen_q < MAX_LEN)) begin
			query_mem[qlen_q[AW-1:0]] <= symbol;
		end
		if (cmd.step) begin
			row_mem[k_q] <= cost;
		end
		q_rd_s1    <= query_mem[rd_addr];
		row_rd_s1  <= row_mem[rd_addr];
		row_vld_s1 <= row_valid_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (restart) begin
			row_valid_q <= '0;
		end else if (cmd.step) begin
			row_valid_q[k_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dict_start) begin
			sym_q  <= symbol;
			last_q <= word_last;
			k_q    <= '0;
			diag_q <= row0_q;
			left_q <= row0_inc;
		end else if (cmd.step) begin
			k_q    <= k_q + AW'(1);
			diag_q <= up;
			left_q <= cost;
		end
		if (cmd.emit) begin
			found_q         <= any_q && (best_q <= max_distance_q);
			best_index_q    <= pos_q;
			best_distance_q <= best_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_distance_q <= 8'd2;
			qlen_q         <= '0;
			row0_q         <= '0;
			cnt_q          <= '0;
			best_q         <= 8'hFF;
			pos_q          <= '0;
			any_q          <= 1'b0;
			done_q         <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cfg_we) begin
				max_distance_q <= cfg_data;
			end
			if (cmd.dict_start) begin
				row0_q <= row0_inc;
			end else if (restart) begin
				row0_q <= '0;
			end
			if (cmd.load_query && (qlen_q < MAX_LEN)) begin
				qlen_q <= qlen_q + LW'(1);
			end
			if (word_end) begin
				if (!any_q || (left_q < best_q)) begin
					best_q <= left_q;
					pos_q  <= cnt_q;
				end
				any_q <= 1'b1;
				cnt_q <= cnt_q + INDEX_BITS'(1);
			end
			if (cmd.emit) begin
				qlen_q <= '0;
				cnt_q  <= '0;
				best_q <= 8'hFF;
				pos_q  <= '0;
				any_q  <= 1'b0;
			end
		end
	end

	assign done          = done_q;
	assign found         = found_q;
	assign best_index    = best_index_q;
	assign best_distance = best_distance_q;

	`ASSERT_IMP(a_qlen_bound, clk, arst_n, 1'b1, qlen_q <= MAX_LEN,
		"query length beyond the query store")
	`ASSERT_NXT(a_emit_clears, clk, arst_n, cmd.emit,
		(qlen_q == '0) && !any_q && (best_q == 8'hFF) && (row_valid_q == '0),
		"search state not cleared after end of dictionary")

endmodule

/* design/nearest_word_edit_distance.sv */
// Query item: stored without raising busy. Dictionary item: a set-up step, one
// step per table cell and a word-end step, all run by the single cell unit.
// End-of-dictionary item: the result strobes for one cycle on done
// in the cycle after acceptance, and busy stays low so a new item may follow.
// Asynchronous active-low reset clears the query, the row, the best match and
// sets max_distance to 2.
module nearest_word_edit_distance #(
	parameter int MAX_WORD   = nwed_pkg::MAX_WORD,
	parameter int INDEX_BITS = nwed_pkg::INDEX_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            mode,
	input  logic [7:0]            symbol,
	input  logic                  word_last,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [7:0]            cfg_data,
	output logic                  done,
	output logic                  found,
	output logic [INDEX_BITS-1:0] best_index,
	output logic [7:0]            best_distance
);

	nwed_pkg::cmd_t cmd;
	nwed_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	nwed_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	nwed_dp #(
		.MAX_WORD   (MAX_WORD),
		.INDEX_BITS (INDEX_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.symbol        (symbol),
		.word_last     (word_last),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.sts           (sts),
		.done          (done),
		.found         (found),
		.best_index    (best_index),
		.best_distance (best_distance)
	);

endmodule

/* tb/nearest_word_edit_distance_checker.sv */
`timescale 1ns / 100ps

module nearest_word_edit_distance_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  logic [1:0]                      mode,
	input  logic [7:0]                      symbol,
	input  logic                            word_last,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [7:0]                      cfg_data,
	input  logic                            done,
	input  logic                            found,
	input  logic [nwed_pkg::INDEX_BITS-1:0] best_index,
	input  logic [7:0]                      best_distance,
	output int                              mismatches,
	output int                              pending
);

	typedef struct packed {
		logic                            found;
		logic [nwed_pkg::INDEX_BITS-1:0] index;
		logic [7:0]                      distance;
	} match_t;

	match_t                          match_q[$];
	logic [7:0]                      max_dist;
	logic [7:0]                      query_buf[nwed_pkg::MAX_WORD];
	int unsigned                     query_len;
	logic [7:0]                      dist_row[nwed_pkg::MAX_WORD + 1];
	logic [7:0]                      row_count;
	logic [nwed_pkg::INDEX_BITS-1:0] word_count;
	logic [7:0]                      best_dist;
	logic [nwed_pkg::INDEX_BITS-1:0] best_pos;
	logic                            word_seen;

	task automatic restart_row();
		int j;
		for (j = 0; j <= nwed_pkg::MAX_WORD; j++) begin
			dist_row[j] = (j > 255) ? 8'd255 : 8'(j);
		end
		row_count = 8'd0;
	endtask

	task automatic clear_search();
		query_len = 0;
		word_count = '0;
		best_dist = 8'd255;
		best_pos = '0;
		word_seen = 1'b0;
		restart_row();
	endtask

	task automatic advance_row(input logic [7:0] c);
		int j;
		int diag;
		int left;
		int up;
		int cost;
		diag = dist_row[0];
		row_count = (row_count == 8'd255) ? 8'd255 : row_count + 8'd1;
		dist_row[0] = row_count;
		left = row_count;
		for (j = 1; j <= query_len; j++) begin
			up = dist_row[j];
			cost = diag + ((query_buf[j - 1] == c) ? 0 : 1);
			if (left + 1 < cost) begin
				cost = left + 1;
			end
			if (up + 1 < cost) begin
				cost = up + 1;
			end
			if (cost > 255) begin
				cost = 255;
			end
			dist_row[j] = 8'(cost);
			diag = up;
			left = cost;
		end
	endtask

	task automatic predict_item(input logic [1:0] m, input logic [7:0] s,
		input logic l);
		logic [7:0] d;
		match_t r;
		case (m)
			nwed_pkg::MODE_QUERY: begin
				if (query_len < nwed_pkg::MAX_WORD) begin
					query_buf[query_len] = s;
					query_len++;
				end
				restart_row();
			end
			nwed_pkg::MODE_DICT: begin
				advance_row(s);
				if (l) begin
					d = dist_row[query_len];
					if (!word_seen || d < best_dist) begin
						best_dist = d;
						best_pos = word_count;
					end
					word_seen = 1'b1;
					word_count = word_count + 1'b1;
					restart_row();
				end
			end
			nwed_pkg::MODE_END: begin
				r.found = word_seen && (best_dist <= max_dist);
				r.index = best_pos;
				r.distance = best_dist;
				match_q.push_back(r);
				clear_search();
			end
			default: begin
			end
		endcase
	endtask

	task automatic compare_result();
		match_t r;
		if (match_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: unexpected result found=%0b index=%0d distance=%0d",
					$time, found, best_index, best_distance);
			end
		end else begin
			r = match_q.pop_front();
			if (found !== r.found || best_index !== r.index ||
				best_distance !== r.distance) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: expected found=%0b index=%0d distance=%0d, %s",
						$time, r.found, r.index, r.distance, "got");
					$display("%0t: got found=%0b index=%0d distance=%0d",
						$time, found, best_index, best_distance);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dist = 8'd2;
			for (int k = 0; k < nwed_pkg::MAX_WORD; k++) begin
				query_buf[k] = 8'd0;
			end
			clear_search();
			match_q.delete();
			mismatches = 0;
		end else begin
			if (done === 1'b1) begin
				compare_result();
			end
			if (cfg_valid && cfg_ready) begin
				max_dist = cfg_data;
			end
			if (start && !busy) begin
				predict_item(mode, symbol, word_last);
			end
		end
		pending = match_q.size();
	end

endmodule

/* tb/nearest_word_edit_distance_tb.sv */
`timescale 1ns / 100ps

module nearest_word_edit_distance_tb;

	localparam logic [1:0] MODE_IGNORED  = 2'd3;
	localparam int         RANDOM_ITEMS  = 600;
	localparam int         SETTLE_CYCLES = nwed_pkg::MAX_WORD + 16;

	typedef logic [7:0] byte_seq_t[$];

	logic                            clk;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	logic [1:0]                      mode;
	logic [7:0]                      symbol;
	logic                            word_last;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [7:0]                      cfg_data;
	logic                            done;
	logic                            found;
	logic [nwed_pkg::INDEX_BITS-1:0] best_index;
	logic [7:0]                      best_distance;

	int         mismatches;
	int         pending;
	int         item_count;
	bit         gaps_on;
	int         burst_left;
	logic [7:0] cfg_value;

	nearest_word_edit_distance dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.symbol       (symbol),
		.word_last    (word_last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.done         (done),
		.found        (found),
		.best_index   (best_index),
		.best_distance(best_distance)
	);

	nearest_word_edit_distance_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.symbol       (symbol),
		.word_last    (word_last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.done         (done),
		.found        (found),
		.best_index   (best_index),
		.best_distance(best_distance),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	always #6 clk = ~clk;

	initial begin
		#40_000_000;
		$display("FAIL nearest_word_edit_distance");
		$finish;
	end

	function automatic logic [7:0] pick_symbol(input bit wide);
		return wide ? 8'($urandom_range(0, 255)) : 8'h61 + 8'($urandom_range(0, 3));
	endfunction

	task automatic send_item(input logic [1:0] m, input logic [7:0] s, input logic l);
		mode = m;
		symbol = s;
		word_last = l;
		start = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
		start = 1'b0;
		if (m != MODE_IGNORED) begin
			item_count++;
		end
		if (gaps_on) begin
			burst_left--;
			if (burst_left <= 0) begin
				mode = 2'($urandom);
				symbol = 8'($urandom);
				word_last = 1'($urandom);
				repeat ($urandom_range(1, 12)) @(negedge clk);
				burst_left = $urandom_range(1, 16);
			end
		end
	endtask

	task automatic send_word(input byte_seq_t w, input logic finish);
		foreach (w[i]) begin
			send_item(nwed_pkg::MODE_DICT, w[i], (i == w.size() - 1) ? finish : 1'b0);
		end
	endtask

	task automatic write_max_distance(input logic [7:0] v);
		wait (pending == 0);
		@(negedge clk);
		while (busy) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_data = v;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_data = 8'($urandom);
	endtask

	task automatic random_search();
		byte_seq_t query;
		byte_seq_t word;
		bit        wide;
		int        qlen;
		int        nwords;
		int        pos;
		int        cut;
		wide = ($urandom_range(0, 3) == 0);
		case ($urandom_range(0, 24))
			0: begin
				qlen = 0;
			end
			1: begin
				qlen = $urandom_range(nwed_pkg::MAX_WORD - 2, nwed_pkg::MAX_WORD + 4);
			end
			default: begin
				qlen = $urandom_range(1, 8);
			end
		endcase
		repeat (qlen) query.push_back(pick_symbol(wide));
		foreach (query[i]) begin
			send_item(nwed_pkg::MODE_QUERY, query[i], 1'($urandom));
		end
		nwords = (qlen > 8) ? $urandom_range(1, 2) : $urandom_range(0, 8);
		repeat (nwords) begin
			word = query;
			if ($urandom_range(0, 5) == 0) begin
				word.delete();
				repeat ($urandom_range(1, 10)) word.push_back(pick_symbol(wide));
			end else begin
				repeat ($urandom_range(0, 3)) begin
					pos = $urandom_range(0, word.size());
					case ($urandom_range(0, 2))
						0: begin
							word.insert(pos, pick_symbol(wide));
						end
						1: begin
							if (pos < word.size()) begin
								word.delete(pos);
							end
						end
						default: begin
							if (pos < word.size()) begin
								word[pos] = pick_symbol(wide);
							end
						end
					endcase
				end
			end
			if (word.size() == 0) begin
				word.push_back(pick_symbol(wide));
			end
			case ($urandom_range(0, 19))
				0: begin
					send_item(MODE_IGNORED, 8'($urandom), 1'($urandom));
				end
				1: begin
					// A query byte in the middle of a word drops the partial word.
					cut = $urandom_range(1, word.size());
					for (int i = 0; i < cut; i++) begin
						send_item(nwed_pkg::MODE_DICT, word[i], 1'b0);
					end
					send_item(nwed_pkg::MODE_QUERY, pick_symbol(wide), 1'($urandom));
				end
				default: begin
				end
			endcase
			send_word(word, 1'b1);
		end
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 4)) begin
				send_item(nwed_pkg::MODE_DICT, pick_symbol(wide), 1'b0);
			end
		end
		send_item(nwed_pkg::MODE_END, 8'($urandom), 1'($urandom));
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		mode = nwed_pkg::MODE_QUERY;
		symbol = 8'd0;
		word_last = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 8'd0;
		gaps_on = 1'b0;
		burst_left = 1;
		item_count = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		write_max_distance(8'd1);
		send_item(nwed_pkg::MODE_END, 8'h00, 1'b0);
		send_item(nwed_pkg::MODE_DICT, 8'h78, 1'b1);
		send_item(nwed_pkg::MODE_DICT, 8'h61, 1'b0);
		send_item(nwed_pkg::MODE_DICT, 8'h62, 1'b1);
		send_item(MODE_IGNORED, 8'hA5, 1'b1);
		send_item(nwed_pkg::MODE_END, 8'hFF, 1'b1);
		send_item(nwed_pkg::MODE_QUERY, 8'h00, 1'b1);
		send_item(nwed_pkg::MODE_QUERY, 8'hFF, 1'b0);
		send_item(nwed_pkg::MODE_DICT, 8'hFF, 1'b1);
		send_item(nwed_pkg::MODE_DICT, 8'h00, 1'b0);
		send_item(nwed_pkg::MODE_DICT, 8'hFF, 1'b1);
		send_item(nwed_pkg::MODE_DICT, 8'h5A, 1'b0);
		send_item(nwed_pkg::MODE_END, 8'h5A, 1'b1);
		send_item(nwed_pkg::MODE_QUERY, 8'h61, 1'b0);
		send_item(nwed_pkg::MODE_DICT, 8'h62, 1'b0);
		send_item(nwed_pkg::MODE_QUERY, 8'h63, 1'b0);
		send_item(nwed_pkg::MODE_DICT, 8'h61, 1'b0);
		send_item(nwed_pkg::MODE_DICT, 8'h63, 1'b1);
		send_item(nwed_pkg::MODE_DICT, 8'h61, 1'b0);
		send_item(nwed_pkg::MODE_DICT, 8'h63, 1'b1);
		send_item(nwed_pkg::MODE_END, 8'h00, 1'b0);

		// Overlong query, then words long enough to saturate every distance.
		write_max_distance(8'd255);
		repeat (nwed_pkg::MAX_WORD + 6) send_item(nwed_pkg::MODE_QUERY, 8'h00, 1'b0);
		for (int i = 0; i < 330; i++) begin
			send_item(nwed_pkg::MODE_DICT, 8'hFF, i == 329);
		end
		send_item(nwed_pkg::MODE_END, 8'h00, 1'b0);
		for (int i = 0; i < 300; i++) begin
			send_item(nwed_pkg::MODE_DICT, 8'h41, i == 299);
		end
		send_item(nwed_pkg::MODE_END, 8'h00, 1'b0);

		write_max_distance(8'd0);
		send_item(nwed_pkg::MODE_QUERY, 8'h61, 1'b0);
		send_item(nwed_pkg::MODE_QUERY, 8'h62, 1'b0);
		send_item(nwed_pkg::MODE_DICT, 8'h61, 1'b1);
		send_item(nwed_pkg::MODE_DICT, 8'h61, 1'b0);
		send_item(nwed_pkg::MODE_DICT, 8'h62, 1'b1);
		send_item(nwed_pkg::MODE_END, 8'h00, 1'b0);

		item_count = 0;
		while (item_count < RANDOM_ITEMS) begin
			case ($urandom_range(0, 5))
				0: begin
					cfg_value = 8'd0;
				end
				1: begin
					cfg_value = 8'd255;
				end
				2: begin
					cfg_value = 8'd1;
				end
				3: begin
					cfg_value = 8'd2;
				end
				default: begin
					cfg_value = 8'($urandom_range(0, 255));
				end
			endcase
			write_max_distance(cfg_value);
			gaps_on = ($urandom_range(0, 3) != 0);
			burst_left = $urandom_range(1, 16);
			repeat ($urandom_range(1, 4)) random_search();
		end

		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("PASS nearest_word_edit_distance");
		end else begin
			$display("FAIL nearest_word_edit_distance");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+design
design/nwed_pkg.sv
design/nwed_ctrl.sv
design/nwed_dp.sv
design/nearest_word_edit_distance.sv
tb/nearest_word_edit_distance_checker.sv
tb/nearest_word_edit_distance_tb.sv
